FILE: rtl/core/hafs_pkg.sv
// ----------------------------------------------------------------------------
// hafs_pkg: shared types and constants of the Annex B frame splitter
// Holds the window geometry, the start code constants and the result type.
// ----------------------------------------------------------------------------
package hafs_pkg;

  // Lookahead depth, plus one slot that takes the end byte during a flush
  localparam int unsigned WinDepth = 5;
  localparam int unsigned WinSlots = WinDepth + 1;
  localparam int unsigned CountW   = $clog2(WinSlots + 1);
  localparam int unsigned LenW     = 3;
  localparam int unsigned SkipW    = 2;

  localparam logic [63:0] MaskReset   = 64'h0000_0087_0018_0002;
  localparam logic [7:0]  NalTypeBits = 8'h7E;
  localparam logic [7:0]  ZeroByte    = 8'h00;
  localparam logic [7:0]  OneByte     = 8'h01;

  localparam logic [LenW-1:0] LenNone  = 3'd0;
  localparam logic [LenW-1:0] LenShort = 3'd3;
  localparam logic [LenW-1:0] LenLong  = 3'd4;

  typedef logic [7:0]                byte_t;
  typedef logic [WinDepth-1:0][7:0]  hafs_view_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } hafs_result_t;

endpackage

FILE: rtl/core/hafs_in_if.sv
// ----------------------------------------------------------------------------
// hafs_in_if: byte stream channel
// Valid/ready channel carrying one stream byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface hafs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       stream_end;

  modport source (output valid, output stream_byte, output stream_end, input ready);
  modport sink   (input valid, input stream_byte, input stream_end, output ready);
endinterface

FILE: rtl/core/hafs_out_if.sv
// ----------------------------------------------------------------------------
// hafs_out_if: framed byte channel
// Valid/ready channel carrying one byte and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface hafs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;

  modport source (output valid, output out_byte, output frame_last, input ready);
  modport sink   (input valid, input out_byte, input frame_last, output ready);
endinterface

FILE: rtl/core/hafs_code_detect.sv
// ----------------------------------------------------------------------------
// hafs_code_detect: enabled start code detector
// Returns 3 or 4 when an enabled start code opens the view, else 0.
// ----------------------------------------------------------------------------
module hafs_code_detect
  import hafs_pkg::*;
(
  input  hafs_view_t      view,
  input  logic [63:0]     mask,
  output logic [LenW-1:0] len
);

  logic       short_code;
  logic       long_code;
  byte_t      hdr;
  logic [5:0] nal_type;

  assign short_code = (view[0] == ZeroByte) && (view[1] == ZeroByte) && (view[2] == OneByte);
  assign long_code  = (view[0] == ZeroByte) && (view[1] == ZeroByte) &&
                      (view[2] == ZeroByte) && (view[3] == OneByte);

  always_comb begin
    hdr = short_code ? view[3] : view[4];
    nal_type = 6'((hdr & NalTypeBits) >> 1);
    len = LenNone;
    if (mask[nal_type]) begin
      if (short_code) begin
        len = LenShort;
      end else if (long_code) begin
        len = LenLong;
      end
    end
  end

endmodule

FILE: rtl/core/hafs_out_stage.sv
// ----------------------------------------------------------------------------
// hafs_out_stage: output register
// Holds one result for the sink; refills in the cycle it is taken.
// ----------------------------------------------------------------------------
module hafs_out_stage
  import hafs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  input  hafs_result_t push_data,
  output logic         push_ready,
  hafs_out_if.source   frames
);

  logic         valid;
  hafs_result_t data;

  assign push_ready = !valid || frames.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push_ready) begin
      valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data <= push_data;
    end
  end

  assign frames.valid      = valid;
  assign frames.out_byte   = data.out_byte;
  assign frames.frame_last = data.frame_last;

endmodule

FILE: rtl/core/hevc_annexb_frame_splitter.sv
// ----------------------------------------------------------------------------
// hevc_annexb_frame_splitter: H.265 Annex B frame splitter
// Passes a byte stream through a five-byte lookahead window and marks the
// last byte of each frame ahead of an enabled start code, and the end byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the sink is ready and no flush runs;
//   the window compare and skip/first-code bookkeeping are combinational.
// Latency: a byte leaves five transfers after it enters, or in the flush at
//   the stream end, then passes through the output register. On an end byte,
//   input stalls as the window drains, one byte per cycle unless stalled.
// Reset: clears the window count and flags, sets the NAL mask to its default.
module hevc_annexb_frame_splitter
  import hafs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  hafs_in_if.sink     stream,
  hafs_out_if.source  frames
);

  // Configuration: NAL type enable mask
  logic [63:0] nal_type_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_type_mask <= MaskReset;
    end else if (cfg_we) begin
      nal_type_mask <= cfg_wdata;
    end
  end

  // Window state; slot WinDepth is used only to hold the end byte on a flush
  byte_t             win [WinSlots];
  byte_t             win_next [WinSlots];
  logic [CountW-1:0] held_count, held_count_next;
  logic              first_seen, first_seen_next;
  logic [SkipW-1:0]  skip, skip_next;
  logic              draining, draining_next;

  logic              in_acc;
  logic              push_valid;
  logic              push_ready;
  hafs_result_t      push_data;
  hafs_view_t        det_view;
  logic [LenW-1:0]   det_len;
  logic              split;

  // Accept input only outside a flush and while the output register can take
  // a result, so an incoming byte never has to wait on its own output.
  assign stream.ready = !draining && push_ready;
  assign in_acc       = stream.valid && stream.ready;

  // Test the position after the oldest byte once the window is full; the
  // stream-start test (fifth byte arriving) looks at the oldest byte itself.
  always_comb begin
    if (held_count == CountW'(WinDepth)) begin
      det_view = {stream.stream_byte, win[4], win[3], win[2], win[1]};
    end else begin
      det_view = {stream.stream_byte, win[3], win[2], win[1], win[0]};
    end
  end

  hafs_code_detect u_detect (
    .view (det_view),
    .mask (nal_type_mask),
    .len  (det_len)
  );

  always_comb begin
    win_next            = win;
    held_count_next     = held_count;
    first_seen_next     = first_seen;
    skip_next           = skip;
    draining_next       = draining;
    push_valid          = 1'b0;
    push_data.out_byte  = win[0];
    push_data.frame_last = 1'b0;
    split               = 1'b0;

    if (draining) begin
      // Flush: advance one held byte per transfer; mark only the end byte
      push_valid = 1'b1;
      push_data.frame_last = (held_count == CountW'(1));
      if (push_ready) begin
        for (int i = 0; i < WinSlots - 1; i++) begin
          win_next[i] = win[i+1];
        end
        held_count_next = CountW'(held_count - CountW'(1));
        if (held_count == CountW'(1)) begin
          draining_next = 1'b0;
        end
      end
    end else if (in_acc) begin
      if (stream.stream_end) begin
        // Append the end byte, drop all stream history, start draining
        win_next[held_count] = stream.stream_byte;
        held_count_next      = CountW'(held_count + CountW'(1));
        draining_next        = 1'b1;
        first_seen_next      = 1'b0;
        skip_next            = '0;
      end else if (held_count < CountW'(WinDepth - 1)) begin
        win_next[held_count] = stream.stream_byte;
        held_count_next      = CountW'(held_count + CountW'(1));
      end else begin
        // Hold off retesting inside a code just found
        if (skip != '0) begin
          skip_next = SkipW'(skip - SkipW'(1));
        end else if (det_len != LenNone) begin
          skip_next       = SkipW'(det_len - LenW'(1));
          split           = first_seen;
          first_seen_next = 1'b1;
        end

        if (held_count == CountW'(WinDepth)) begin
          push_valid           = 1'b1;
          push_data.frame_last = split;
          for (int i = 0; i < WinDepth - 1; i++) begin
            win_next[i] = win[i+1];
          end
          win_next[WinDepth-1] = stream.stream_byte;
        end else begin
          win_next[WinDepth-1] = stream.stream_byte;
          held_count_next      = CountW'(WinDepth);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      first_seen <= 1'b0;
      skip       <= '0;
      draining   <= 1'b0;
    end else begin
      held_count <= held_count_next;
      first_seen <= first_seen_next;
      skip       <= skip_next;
      draining   <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  hafs_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .frames     (frames)
  );

  // Window never holds more than the lookahead plus the end byte
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CountW'(WinSlots))
    else $error("window count out of range");

  // No byte enters while the window flushes
  a_no_accept_in_flush: assert property (@(posedge clk) disable iff (rst)
    draining |-> !stream.ready)
    else $error("input taken during flush");

  // Transfer of the end byte closes the flush with an empty window
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (draining && push_ready && held_count == CountW'(1)) |=>
      (!draining && held_count == '0 && !first_seen))
    else $error("flush did not finish cleanly");

  // A flush is entered only from an accepted end byte
  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    (!draining && !(in_acc && stream.stream_end)) |=> !draining)
    else $error("flush started without an end byte");

endmodule

FILE: tb/tb_hevc_annexb_frame_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hevc_annexb_frame_splitter: self-checking bench for the frame splitter
// Feeds Annex B byte streams with random stalls on both channels. A local
// model of the lookahead window predicts every framed byte and its frame
// mark, and each output transfer is compared against the oldest prediction.
// The NAL type mask is changed between streams, its extremes among them.
// ----------------------------------------------------------------------------
module tb_hevc_annexb_frame_splitter;
  import hafs_pkg::*;

  localparam int unsigned DirectedItems = 25;
  localparam int unsigned RandomItems   = 305;
  localparam int unsigned PhaseItems    = 45;
  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned MaxReports    = 10;

  // Window model plus the queue of framed bytes it has predicted.
  class frame_mark_checker;
    logic [63:0]  type_mask;
    byte_t        window [WinDepth];
    int unsigned  held;
    bit           code_seen;
    int unsigned  skip_left;
    hafs_result_t marks_due [$];
    int unsigned  errors;

    function new();
      type_mask = MaskReset;
      errors    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window[i]) window[i] = ZeroByte;
      held      = 0;
      code_seen = 0;
      skip_left = 0;
    endfunction

    // Length of an enabled start code at v[0], zero when there is none.
    function int unsigned code_len(byte_t v [WinDepth]);
      byte_t       hdr;
      byte_t       nal;
      int unsigned len;
      if (v[0] == ZeroByte && v[1] == ZeroByte && v[2] == OneByte) begin
        len = LenShort;
        hdr = v[3];
      end else if (v[0] == ZeroByte && v[1] == ZeroByte && v[2] == ZeroByte &&
                   v[3] == OneByte) begin
        len = LenLong;
        hdr = v[4];
      end else begin
        return LenNone;
      end
      nal = (hdr & NalTypeBits) >> 1;
      return type_mask[nal[5:0]] ? len : LenNone;
    endfunction

    // Test one position; return 1 when a frame ends just before it.
    function bit boundary_at(byte_t v [WinDepth]);
      int unsigned len;
      if (skip_left > 0) begin
        skip_left--;
        return 1'b0;
      end
      len = code_len(v);
      if (len == 0) return 1'b0;
      skip_left = len - 1;
      if (code_seen) return 1'b1;
      code_seen = 1'b1;
      return 1'b0;
    endfunction

    function void note_byte(byte_t b, logic last);
      byte_t probe [WinDepth];
      byte_t oldest;
      bit    split;
      if (last) begin
        // Flush: every held byte unmarked, the end byte marked.
        for (int i = 0; i < held; i++)
          marks_due.push_back('{out_byte: window[i], frame_last: 1'b0});
        marks_due.push_back('{out_byte: b, frame_last: 1'b1});
        clear_stream();
      end else if (held < WinDepth - 1) begin
        window[held] = b;
        held++;
      end else if (held == WinDepth - 1) begin
        window[WinDepth-1] = b;
        held = WinDepth;
        split = boundary_at(window);
      end else begin
        oldest = window[0];
        for (int i = 0; i < WinDepth - 1; i++) probe[i] = window[i+1];
        probe[WinDepth-1] = b;
        split = boundary_at(probe);
        marks_due.push_back('{out_byte: oldest, frame_last: split});
        foreach (window[i]) window[i] = probe[i];
      end
    endfunction

    function void check_byte(byte_t b, logic last);
      hafs_result_t want;
      if (marks_due.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("unexpected output: out_byte %h frame_last %b", b, last);
        return;
      end
      want = marks_due.pop_front();
      if (want.out_byte !== b || want.frame_last !== last) begin
        errors++;
        if (errors <= MaxReports)
          $display("mismatch: out_byte exp %h got %h, frame_last exp %b got %b",
                   want.out_byte, b, want.frame_last, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  hafs_in_if  stream_ch ();
  hafs_out_if frame_ch ();

  hevc_annexb_frame_splitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stream    (stream_ch.sink),
    .frames    (frame_ch.source)
  );

  frame_mark_checker sb = new();

  byte_t       unit [$];       // bytes of the stream about to be sent
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          steady_flow;    // when set, neither side inserts gaps

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Zeros and ones are frequent so that stray start codes show up.
  function automatic byte_t biased_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return ZeroByte;
    if (r == 3) return OneByte;
    return byte_t'($urandom);
  endfunction

  // Pick a NAL type that the current mask enables (or disables).
  function automatic logic [5:0] pick_type(bit enabled);
    logic [5:0] t;
    for (int i = 0; i < 256; i++) begin
      t = 6'($urandom_range(0, 63));
      if (sb.type_mask[t] == enabled) return t;
    end
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic byte_t header_for(logic [5:0] nal);
    byte_t h;
    h      = byte_t'($urandom);
    h[6:1] = nal;
    return h;
  endfunction

  function automatic void add_code(bit enabled);
    if ($urandom_range(0, 1) == 1) unit.push_back(ZeroByte);
    unit.push_back(ZeroByte);
    unit.push_back(ZeroByte);
    unit.push_back(OneByte);
    unit.push_back(header_for(pick_type(enabled)));
  endfunction

  // A well-formed stream: frames that open with a start code, random payload.
  function automatic void build_frames();
    int unsigned frames_n;
    int unsigned payload_n;
    unit.delete();
    frames_n = $urandom_range(1, 4);
    for (int f = 0; f < frames_n; f++) begin
      add_code($urandom_range(0, 9) < 8);
      payload_n = $urandom_range(0, 10);
      for (int p = 0; p < payload_n; p++) begin
        if ($urandom_range(0, 9) == 0) add_code(1'b0);
        else unit.push_back(biased_byte());
      end
    end
  endfunction

  // Noise, broken codes, short streams and streams cut inside a code.
  function automatic void build_noise();
    int unsigned n;
    unit.delete();
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) unit.push_back(biased_byte());
      end
      1: begin
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) begin
          unit.push_back(ZeroByte);
          unit.push_back(ZeroByte);
          unit.push_back(byte_t'($urandom_range(0, 3)));
          unit.push_back(biased_byte());
        end
      end
      2: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) unit.push_back(biased_byte());
      end
      default: begin
        add_code(1'b1);
        n = $urandom_range(1, unit.size());
        while (unit.size() > n) void'(unit.pop_back());
      end
    endcase
  endfunction

  function automatic logic [63:0] phase_mask(int unsigned k);
    case (k % 7)
      0:       return '1;
      1:       return '0;
      2:       return MaskReset;
      3:       return 64'h8000_0000_0000_0000;
      4:       return 64'h0000_0000_0000_0001;
      5:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Hold the sender until every predicted byte has come out.
  task automatic drain();
    stream_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.marks_due.size() != 0);
  endtask

  // Write the mask only with the window empty and the output settled.
  task automatic write_mask(logic [63:0] value);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.type_mask  = value;
  endtask

  task automatic send_byte(byte_t b, logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    stream_ch.stream_end  <= last;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send the unit as one stream; its last byte carries the end mark.
  task automatic send_unit(bit pause);
    int pause_at;
    pause_at = pause ? $urandom_range(unit.size() / 2, unit.size() - 1) : -1;
    for (int i = 0; i < unit.size(); i++) begin
      if (i == pause_at) drain();
      send_byte(unit[i], i == unit.size() - 1);
    end
  endtask

  // Sink: random stalls between bursts of ready.
  initial begin
    int unsigned gap;
    frame_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = gap_len();
      if (gap > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Note every input transfer before checking the output transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (stream_ch.valid && stream_ch.ready)
        sb.note_byte(stream_ch.stream_byte, stream_ch.stream_end);
      if (frame_ch.valid && frame_ch.ready)
        sb.check_byte(frame_ch.out_byte, frame_ch.frame_last);
    end
  end

  // Watchdog: count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) ||
        (frame_ch.valid && frame_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("** hevc_annexb_frame_splitter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    bit          paused_once;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    stream_ch.valid       <= 1'b0;
    stream_ch.stream_byte <= ZeroByte;
    stream_ch.stream_end  <= 1'b0;
    items_sent             = 0;
    steady_flow            = 1'b0;
    paused_once            = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset mask (types 1, 19, 20, 32, 33, 34, 39).
    // Lone end byte: nothing held, the byte itself is marked.
    unit = '{8'hFF};
    send_unit(1'b0);
    // Stream shorter than the window, flushed at its end byte.
    unit = '{8'h00, 8'h00, 8'h01};
    send_unit(1'b0);
    // Opening code (type 32) never splits, a disabled code (type 63) is
    // passed over, and a 4-byte code (type 19) splits; its inner 3-byte
    // code must not be found again.
    unit = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01,
             8'h00, 8'h00, 8'h01, 8'hFF,
             8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01,
             8'h80};
    send_unit(1'b0);
    // Enabled code inside the last five positions: flushed, not tested.
    unit = '{8'h00, 8'h00, 8'h01, 8'h26, 8'h7E};
    send_unit(1'b0);

    // Random: well-formed streams mostly, a mask phase every few dozen bytes.
    phase       = 0;
    phase_start = items_sent;
    write_mask(phase_mask(phase));
    while (items_sent < DirectedItems + RandomItems) begin
      if (items_sent - phase_start >= PhaseItems) begin
        phase++;
        phase_start = items_sent;
        write_mask(phase_mask(phase));
      end
      steady_flow = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) build_frames();
      else build_noise();
      send_unit(!paused_once || $urandom_range(0, 7) == 0);
      paused_once = 1'b1;
    end
    steady_flow = 1'b0;

    // Wait for the last framed bytes, then allow the output register to settle.
    drain();
    repeat (20) @(posedge clk);
    if (sb.marks_due.size() != 0)
      $display("%0d predicted bytes never came out", sb.marks_due.size());
    if (sb.errors == 0 && sb.marks_due.size() == 0) begin
      $display("** hevc_annexb_frame_splitter: PASSED **");
    end else begin
      $display("** hevc_annexb_frame_splitter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/hafs_pkg.sv
rtl/core/hafs_in_if.sv
rtl/core/hafs_out_if.sv
rtl/core/hafs_code_detect.sv
rtl/core/hafs_out_stage.sv
rtl/core/hevc_annexb_frame_splitter.sv
tb/tb_hevc_annexb_frame_splitter.sv
